// ===== sv/bmhq_pkg.sv =====
// Shared types, field widths and codes for the binary max-heap queue.
package bmhq_pkg;

  localparam int PRIO_W   = 16;
  localparam int TAG_W    = 16;
  localparam int STATUS_W = 2;
  localparam int FILL_W   = 7;

  // Operation codes of a request.
  localparam logic CMD_INSERT  = 1'b0;
  localparam logic CMD_EXTRACT = 1'b1;

  // Status codes of a response.
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  // One heap word: priority in the upper half, tag in the lower half.
  typedef struct packed {
    logic [PRIO_W-1:0] prio;
    logic [TAG_W-1:0]  tag;
  } entry_t;

  typedef struct packed {
    logic              cmd;
    logic [PRIO_W-1:0] prio;
    logic [TAG_W-1:0]  tag;
  } req_t;

  typedef struct packed {
    logic [TAG_W-1:0]    out_tag;
    logic [PRIO_W-1:0]   out_prio;
    logic [STATUS_W-1:0] status;
    logic [FILL_W-1:0]   fill;
  } rsp_t;

  // Operands of the shared priority comparator.
  typedef struct packed {
    entry_t base;
    entry_t a;
    logic   a_vld;
    entry_t b;
    logic   b_vld;
  } cmp_req_t;

  // Which operand holds the largest priority.
  typedef enum logic [1:0] {
    SEL_BASE = 2'd0,
    SEL_A    = 2'd1,
    SEL_B    = 2'd2
  } cmp_sel_t;

endpackage

// ===== sv/bmhq_stream_if.sv =====
// Valid/ready stream channel carrying one payload struct per request.
interface bmhq_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== sv/bmhq_ram.sv =====
// Heap storage: one write port and two read ports with registered read data.
module bmhq_ram #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic             clk,
  input  logic             wen,
  input  logic [AW-1:0]    waddr,
  input  bmhq_pkg::entry_t wdata,
  input  logic [AW-1:0]    raddr_a,
  input  logic [AW-1:0]    raddr_b,
  output bmhq_pkg::entry_t rdata_a,
  output bmhq_pkg::entry_t rdata_b
);
  import bmhq_pkg::*;

  entry_t mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wen) begin
      mem[waddr] <= wdata;
    end
  end

  // Two read ports, data valid in the cycle after the address.
  always_ff @(posedge clk) begin
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

// ===== sv/bmhq_cmp.sv =====
// Shared priority comparator: picks the largest of up to three entries.
module bmhq_cmp (
  input  bmhq_pkg::cmp_req_t cmp_in,
  output bmhq_pkg::cmp_sel_t sel
);
  import bmhq_pkg::*;

  logic [PRIO_W-1:0] best_prio;

  // The first operand wins ties; a later one must be strictly greater.
  always_comb begin
    sel       = SEL_BASE;
    best_prio = cmp_in.base.prio;
    if (cmp_in.a_vld && (cmp_in.a.prio > best_prio)) begin
      sel       = SEL_A;
      best_prio = cmp_in.a.prio;
    end
    if (cmp_in.b_vld && (cmp_in.b.prio > best_prio)) begin
      sel = SEL_B;
    end
  end

endmodule

// ===== sv/binary_max_heap_queue.sv =====
// Binary max-heap priority queue; one request in flight, one response per request.
// Each heap level takes one memory read and one pass of the shared comparator.
// A new request is taken while a response waits.
// Reset: synchronous, clears the entry count and the control state; the heap memory is
// not cleared, since only slots within the count are ever used.
module binary_max_heap_queue #(
  parameter int CAPACITY = 64
) (
  input logic          clk,
  input logic          rst,
  bmhq_stream_if.sink   req,
  bmhq_stream_if.source rsp
);
  import bmhq_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  typedef enum logic [6:0] {
    S_IDLE      = 7'b0000001,
    S_UP_READ   = 7'b0000010,
    S_UP_CMP    = 7'b0000100,
    S_LAST_READ = 7'b0001000,
    S_DN_READ   = 7'b0010000,
    S_DN_CMP    = 7'b0100000,
    S_DONE      = 7'b1000000
  } state_t;

  state_t              state;
  logic [CW-1:0]       count;
  logic [CW-1:0]       pos;
  entry_t              cur;
  entry_t              root;
  entry_t              res_word;
  logic [STATUS_W-1:0] res_status;
  logic                rsp_valid;
  rsp_t                rsp_data;

  logic [CW:0]   l_slot;
  logic [CW:0]   r_slot;
  logic [CW:0]   l_idx;
  logic [CW-1:0] parent_slot;
  logic [CW-1:0] parent_idx;
  logic [CW-1:0] last_idx;
  logic [CW-1:0] pos_idx;
  logic          pos_is_root;

  logic          wen;
  logic [AW-1:0] raddr_a;
  entry_t        wdata;
  entry_t        rdata_a;
  entry_t        rdata_b;
  cmp_req_t      cmp_in;
  cmp_sel_t      sel;
  logic          accept;
  entry_t        req_entry;

  // Slot arithmetic; slots count from 1, memory words from 0.
  assign l_slot      = {pos, 1'b0};
  assign r_slot      = l_slot + (CW + 1)'(1);
  assign l_idx       = l_slot - (CW + 1)'(1);
  assign parent_slot = pos >> 1;
  assign parent_idx  = parent_slot - CW'(1);
  assign last_idx    = count - CW'(1);
  assign pos_idx     = pos - CW'(1);
  assign pos_is_root = (pos == CW'(1));

  assign req.ready      = (state == S_IDLE);
  assign accept         = req.valid && req.ready;
  assign req_entry.prio = req.data.prio;
  assign req_entry.tag  = req.data.tag;
  assign rsp.valid      = rsp_valid;
  assign rsp.data       = rsp_data;

  bmhq_ram #(
    .DEPTH (CAPACITY),
    .AW    (AW)
  ) u_ram (
    .clk     (clk),
    .wen     (wen),
    .waddr   (pos_idx[AW-1:0]),
    .wdata   (wdata),
    .raddr_a (raddr_a),
    .raddr_b (l_slot[AW-1:0]),
    .rdata_a (rdata_a),
    .rdata_b (rdata_b)
  );

  bmhq_cmp u_cmp (
    .cmp_in (cmp_in),
    .sel    (sel)
  );

  // Read address: parent when climbing, left child when descending, else the last slot.
  always_comb begin
    unique case (state)
      S_UP_READ: raddr_a = parent_idx[AW-1:0];
      S_DN_READ: raddr_a = l_idx[AW-1:0];
      default:   raddr_a = last_idx[AW-1:0];
    endcase
  end

  // Comparator operands: when climbing the parent is the base and the moving entry
  // challenges it; when descending the moving entry faces the children present.
  always_comb begin
    if (state == S_UP_CMP) begin
      cmp_in.base  = rdata_a;
      cmp_in.a     = cur;
      cmp_in.a_vld = 1'b1;
      cmp_in.b     = rdata_b;
      cmp_in.b_vld = 1'b0;
    end else begin
      cmp_in.base  = cur;
      cmp_in.a     = rdata_a;
      cmp_in.a_vld = (l_slot <= {1'b0, count});
      cmp_in.b     = rdata_b;
      cmp_in.b_vld = (r_slot <= {1'b0, count});
    end
  end

  // Memory write at the current hole: either the entry moving past it or the final one.
  always_comb begin
    wen   = 1'b0;
    wdata = cur;
    unique case (state)
      S_UP_READ: begin
        wen = pos_is_root;
      end
      S_UP_CMP: begin
        wen   = 1'b1;
        wdata = (sel == SEL_A) ? rdata_a : cur;
      end
      S_DN_CMP: begin
        wen = 1'b1;
        unique case (sel)
          SEL_A:   wdata = rdata_a;
          SEL_B:   wdata = rdata_b;
          default: wdata = cur;
        endcase
      end
      default: begin
        wen = 1'b0;
      end
    endcase
  end

  // Root copy follows every write to the first slot.
  always_ff @(posedge clk) begin
    if (wen && pos_is_root) begin
      root <= wdata;
    end
  end

  // Sequencer and response register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      // A taken response is dropped unless a new one replaces it in this cycle.
      if (rsp_valid && rsp.ready && (state != S_DONE)) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            if (req.data.cmd == CMD_INSERT) begin
              if (count == CW'(CAPACITY)) begin
                res_word   <= root;
                res_status <= ST_FULL;
                state      <= S_DONE;
              end else begin
                res_status <= ST_OK;
                cur        <= req_entry;
                count      <= count + CW'(1);
                pos        <= count + CW'(1);
                state      <= S_UP_READ;
              end
            end else begin
              if (count == '0) begin
                res_word   <= '0;
                res_status <= ST_EMPTY;
                state      <= S_DONE;
              end else begin
                res_status <= ST_OK;
                res_word   <= root;
                count      <= count - CW'(1);
                state      <= S_LAST_READ;
              end
            end
          end
        end
        S_UP_READ: begin
          if (pos_is_root) begin
            res_word <= cur;
            state    <= S_DONE;
          end else begin
            state <= S_UP_CMP;
          end
        end
        S_UP_CMP: begin
          if (sel == SEL_A) begin
            pos   <= parent_slot;
            state <= S_UP_READ;
          end else begin
            res_word <= root;
            state    <= S_DONE;
          end
        end
        S_LAST_READ: begin
          if (count == '0) begin
            state <= S_DONE;
          end else begin
            cur   <= rdata_a;
            pos   <= CW'(1);
            state <= S_DN_READ;
          end
        end
        S_DN_READ: begin
          state <= S_DN_CMP;
        end
        S_DN_CMP: begin
          unique case (sel)
            SEL_A: begin
              pos   <= l_slot[CW-1:0];
              state <= S_DN_READ;
            end
            SEL_B: begin
              pos   <= r_slot[CW-1:0];
              state <= S_DN_READ;
            end
            default: begin
              state <= S_DONE;
            end
          endcase
        end
        S_DONE: begin
          if (!rsp_valid || rsp.ready) begin
            rsp_valid         <= 1'b1;
            rsp_data.out_tag  <= res_word.tag;
            rsp_data.out_prio <= res_word.prio;
            rsp_data.status   <= res_status;
            rsp_data.fill     <= FILL_W'(count);
            state             <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== dv/binary_max_heap_queue_test.sv =====
// Self-checking testbench for the binary max-heap queue: directed table, then random phases.
`timescale 1ns / 100ps

module binary_max_heap_queue_test;
  import bmhq_pkg::*;

  localparam int HEAP_DEPTH   = 64;
  localparam int RANDOM_ITEMS = 1300;
  localparam int TAIL_CYCLES  = 40;
  localparam int CYCLE_LIMIT  = 500_000;
  localparam int TABLE_ROWS   = 23;

  // One row of the directed table; the reply is typed in only where it is obvious.
  typedef struct packed {
    logic                cmd;
    logic [PRIO_W-1:0]   prio;
    logic [TAG_W-1:0]    tag;
    logic                fixed;
    logic [TAG_W-1:0]    exp_tag;
    logic [PRIO_W-1:0]   exp_prio;
    logic [STATUS_W-1:0] exp_status;
    logic [FILL_W-1:0]   exp_fill;
  } table_row_t;

  logic clk;
  logic rst;

  bmhq_stream_if #(.payload_t(req_t)) req_ch ();
  bmhq_stream_if #(.payload_t(rsp_t)) rsp_ch ();

  binary_max_heap_queue #(
    .CAPACITY(HEAP_DEPTH)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  // Shadow copy of the heap, kept in step with accepted requests.
  entry_t      heap_mem [1:HEAP_DEPTH];
  int unsigned heap_count;
  rsp_t        awaited_rsps [$];
  int unsigned mismatch_count;
  int unsigned cycle_count;
  bit          src_idle;
  bit          snk_idle;

  table_row_t  directed_rows [TABLE_ROWS] = '{
    '{CMD_EXTRACT, 16'h0000, 16'h0000, 1'b1, 16'h0000, 16'h0000, ST_EMPTY, 7'd0},
    '{CMD_INSERT,  16'h0000, 16'h0000, 1'b1, 16'h0000, 16'h0000, ST_OK,    7'd1},
    '{CMD_INSERT,  16'hFFFF, 16'hFFFF, 1'b1, 16'hFFFF, 16'hFFFF, ST_OK,    7'd2},
    '{CMD_INSERT,  16'hFFFF, 16'h5555, 1'b1, 16'hFFFF, 16'hFFFF, ST_OK,    7'd3},
    '{CMD_INSERT,  16'h8000, 16'hAAAA, 1'b0, 16'h0000, 16'h0000, ST_OK,    7'd0},
    '{CMD_INSERT,  16'h7FFF, 16'h0001, 1'b0, 16'h0000, 16'h0000, ST_OK,    7'd0},
    '{CMD_INSERT,  16'h0001, 16'hFFFE, 1'b0, 16'h0000, 16'h0000, ST_OK,    7'd0},
    '{CMD_INSERT,  16'hFFFE, 16'h8000, 1'b0, 16'h0000, 16'h0000, ST_OK,    7'd0},
    '{CMD_EXTRACT, 16'h0000, 16'h0000, 1'b0, 16'h0000, 16'h0000, ST_OK,    7'd0},
    '{CMD_EXTRACT, 16'h0000, 16'h0000, 1'b0, 16'h0000, 16'h0000, ST_OK,    7'd0},
    '{CMD_EXTRACT, 16'hFFFF, 16'hFFFF, 1'b0, 16'h0000, 16'h0000, ST_OK,    7'd0},
    '{CMD_EXTRACT, 16'h0000, 16'h0000, 1'b0, 16'h0000, 16'h0000, ST_OK,    7'd0},
    '{CMD_EXTRACT, 16'h1234, 16'h4321, 1'b0, 16'h0000, 16'h0000, ST_OK,    7'd0},
    '{CMD_EXTRACT, 16'h0000, 16'h0000, 1'b0, 16'h0000, 16'h0000, ST_OK,    7'd0},
    '{CMD_EXTRACT, 16'h0000, 16'h0000, 1'b0, 16'h0000, 16'h0000, ST_OK,    7'd0},
    '{CMD_EXTRACT, 16'h0000, 16'h0000, 1'b1, 16'h0000, 16'h0000, ST_EMPTY, 7'd0},
    '{CMD_INSERT,  16'h0005, 16'h0100, 1'b0, 16'h0000, 16'h0000, ST_OK,    7'd0},
    '{CMD_INSERT,  16'h0005, 16'h0101, 1'b0, 16'h0000, 16'h0000, ST_OK,    7'd0},
    '{CMD_INSERT,  16'h0005, 16'h0102, 1'b0, 16'h0000, 16'h0000, ST_OK,    7'd0},
    '{CMD_EXTRACT, 16'h0000, 16'h0000, 1'b0, 16'h0000, 16'h0000, ST_OK,    7'd0},
    '{CMD_EXTRACT, 16'h0000, 16'h0000, 1'b0, 16'h0000, 16'h0000, ST_OK,    7'd0},
    '{CMD_EXTRACT, 16'h0000, 16'h0000, 1'b0, 16'h0000, 16'h0000, ST_OK,    7'd0},
    '{CMD_EXTRACT, 16'hFFFF, 16'h0000, 1'b1, 16'h0000, 16'h0000, ST_EMPTY, 7'd0}
  };

  // Clock with an 8 ns period.
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Watchdog on the whole run.
  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("binary_max_heap_queue_test failed");
      $finish;
    end
  end

  // Applies one request to the shadow heap and returns the reply it should give.
  function automatic rsp_t heap_apply(input req_t r);
    rsp_t        reply;
    entry_t      top;
    entry_t      held;
    int unsigned pos;
    int unsigned up;
    int unsigned best;
    int unsigned lc;
    bit          settled;
    reply = '0;
    top   = '0;
    if (r.cmd == CMD_INSERT) begin
      if (heap_count >= HEAP_DEPTH) begin
        reply.status = ST_FULL;
        top          = heap_mem[1];
      end else begin
        heap_count++;
        pos                = heap_count;
        heap_mem[pos].prio = r.prio;
        heap_mem[pos].tag  = r.tag;
        settled            = 1'b0;
        // Sift up while the parent holds a strictly smaller priority.
        while (pos > 1 && !settled) begin
          up = pos / 2;
          if (heap_mem[up].prio < heap_mem[pos].prio) begin
            held          = heap_mem[up];
            heap_mem[up]  = heap_mem[pos];
            heap_mem[pos] = held;
            pos           = up;
          end else begin
            settled = 1'b1;
          end
        end
        reply.status = ST_OK;
        top          = heap_mem[1];
      end
    end else if (heap_count == 0) begin
      reply.status = ST_EMPTY;
    end else begin
      top         = heap_mem[1];
      heap_mem[1] = heap_mem[heap_count];
      heap_count--;
      pos     = 1;
      settled = 1'b0;
      // Sift down: left child if strictly greater, then right if greater than that.
      while (!settled) begin
        best = pos;
        lc   = 2 * pos;
        if (lc <= heap_count && heap_mem[lc].prio > heap_mem[best].prio) best = lc;
        if (lc + 1 <= heap_count && heap_mem[lc + 1].prio > heap_mem[best].prio) best = lc + 1;
        if (best == pos) begin
          settled = 1'b1;
        end else begin
          held           = heap_mem[pos];
          heap_mem[pos]  = heap_mem[best];
          heap_mem[best] = held;
          pos            = best;
        end
      end
      reply.status = ST_OK;
    end
    reply.out_tag  = top.tag;
    reply.out_prio = top.prio;
    reply.fill     = FILL_W'(heap_count);
    return reply;
  endfunction

  task automatic flag_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    mismatch_count++;
  endtask

  // Presents one request, after a random gap when the source idles, and records the reply it should give.
  task automatic send_request(input req_t r, input bit fixed, input rsp_t fixed_rsp);
    int   gap;
    rsp_t predicted;
    gap = src_idle ? $urandom_range(0, 10) : 0;
    @(negedge clk);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.data  <= r;
    do @(posedge clk); while (req_ch.ready !== 1'b1);
    predicted = heap_apply(r);
    if (fixed) begin
      predicted = fixed_rsp;
    end
    awaited_rsps = {awaited_rsps, predicted};
  endtask

  // Compares one reply, field by field, with the oldest one awaited.
  task automatic check_reply(input rsp_t got);
    rsp_t want;
    if (awaited_rsps.size() == 0) begin
      flag_mismatch($sformatf("reply with no request waiting: tag %h prio %h status %0d fill %0d",
                              got.out_tag, got.out_prio, got.status, got.fill));
    end else begin
      want = awaited_rsps.pop_front();
      if (got.out_tag !== want.out_tag)
        flag_mismatch($sformatf("out_tag %h, wanted %h", got.out_tag, want.out_tag));
      if (got.out_prio !== want.out_prio)
        flag_mismatch($sformatf("out_prio %h, wanted %h", got.out_prio, want.out_prio));
      if (got.status !== want.status)
        flag_mismatch($sformatf("status %0d, wanted %0d", got.status, want.status));
      if (got.fill !== want.fill)
        flag_mismatch($sformatf("fill %0d, wanted %0d", got.fill, want.fill));
    end
  endtask

  // Draws a priority, mixing full range, a narrow band for ties, and extremes.
  function automatic logic [PRIO_W-1:0] draw_prio();
    logic [PRIO_W-1:0] p;
    case ($urandom_range(0, 3))
      0, 1: p = PRIO_W'($urandom_range(0, 16'hFFFF));
      2: p = PRIO_W'($urandom_range(0, 3));
      default: begin
        case ($urandom_range(0, 3))
          0: p = 16'h0000;
          1: p = 16'hFFFF;
          2: p = 16'h7FFF;
          default: p = 16'h8000;
        endcase
      end
    endcase
    return p;
  endfunction

  // Reply side: random stalls when the sink idles, check on every accepted reply.
  initial begin
    int gap;
    rsp_ch.ready = 1'b0;
    wait (rst == 1'b0);
    forever begin
      gap = snk_idle ? $urandom_range(0, 10) : 0;
      @(negedge clk);
      if (gap > 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      rsp_ch.ready <= 1'b1;
      do @(posedge clk); while (rsp_ch.valid !== 1'b1);
      check_reply(rsp_ch.data);
    end
  end

  // Request side: reset, directed table, random phases, then drain.
  initial begin
    req_t        r;
    rsp_t        fixed_rsp;
    table_row_t  row;
    int unsigned sent;
    int unsigned phase_len;
    int unsigned insert_pct;
    int unsigned idle_mode;
    rst            = 1'b1;
    req_ch.valid   = 1'b0;
    req_ch.data    = '0;
    heap_count     = 0;
    mismatch_count = 0;
    src_idle       = 1'b0;
    snk_idle       = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed table, with light idling on both sides.
    src_idle = 1'b1;
    snk_idle = 1'b1;
    foreach (directed_rows[i]) begin
      row                = directed_rows[i];
      r.cmd              = row.cmd;
      r.prio             = row.prio;
      r.tag              = row.tag;
      fixed_rsp.out_tag  = row.exp_tag;
      fixed_rsp.out_prio = row.exp_prio;
      fixed_rsp.status   = row.exp_status;
      fixed_rsp.fill     = row.exp_fill;
      send_request(r, row.fixed, fixed_rsp);
    end

    // Random phases: balanced, filling up to and past full, draining past empty.
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      phase_len = $urandom_range(20, 120);
      case ($urandom_range(0, 3))
        0: insert_pct = 50;
        1: insert_pct = 85;
        2: insert_pct = 15;
        default: insert_pct = 95;
      endcase
      idle_mode = $urandom_range(0, 3);
      src_idle  = idle_mode[0];
      snk_idle  = idle_mode[1];
      repeat (phase_len) begin
        r.cmd  = ($urandom_range(1, 100) <= insert_pct) ? CMD_INSERT : CMD_EXTRACT;
        r.prio = draw_prio();
        r.tag  = TAG_W'($urandom_range(0, 16'hFFFF));
        send_request(r, 1'b0, '0);
        sent++;
      end
    end
    @(negedge clk);
    req_ch.valid <= 1'b0;

    // Wait for every awaited reply, then a tail for stray replies.
    wait (awaited_rsps.size() == 0);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("binary_max_heap_queue_test passed");
    end else begin
      $display("binary_max_heap_queue_test failed");
    end
    $finish;
  end

endmodule
